### sv/lru_page_replacement_unit_macros.svh
// Assertion macros for the LRU page replacement unit.
// Used by the top level only; no other dependencies.
`ifndef LRU_PAGE_REPLACEMENT_UNIT_MACROS_SVH
`define LRU_PAGE_REPLACEMENT_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define LPR_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define LPR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/lpr_pkg.sv
// Shared types and constants of the LRU page replacement unit.
// No dependencies.
package lpr_pkg;

   localparam int DEF_MAX_FRAMES  = 8;
   localparam int DEF_PAGE_WIDTH  = 8;
   localparam int DEF_COUNT_WIDTH = 16;

   localparam int CFG_WIDTH = 4;
   localparam logic [CFG_WIDTH-1:0] CFG_FRAMES_RESET = 4'd8;

   typedef enum logic [1:0] {
      ACC_HIT,
      ACC_FILL,
      ACC_EVICT
   } acc_kind_type;

   typedef struct packed {
      logic         en;
      acc_kind_type kind;
   } lpr_update_type;

endpackage

### sv/lpr_frame_table.sv
// Frame table: page held by each slot, fill count, parallel lookup and
// hit/fill/evict decision. Depends on lpr_pkg.
module lpr_frame_table
   import lpr_pkg::*;
#(
   parameter int MAX_FRAMES = DEF_MAX_FRAMES,
   parameter int PAGE_WIDTH = DEF_PAGE_WIDTH,
   localparam int SLOT_WIDTH = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1,
   localparam int FILL_WIDTH = $clog2(MAX_FRAMES + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [PAGE_WIDTH-1:0] lookup_page,
   input  logic [FILL_WIDTH-1:0] limit,
   input  logic [SLOT_WIDTH-1:0] victim_slot,
   input  lpr_update_type        upd,
   output acc_kind_type          kind,
   output logic [SLOT_WIDTH-1:0] access_slot,
   output logic [PAGE_WIDTH-1:0] evicted_page,
   output logic [FILL_WIDTH-1:0] filled
);

   logic [PAGE_WIDTH-1:0] frame_page_ff [MAX_FRAMES];
   logic [FILL_WIDTH-1:0] filled_ff;
   logic                  hit_found;
   logic [SLOT_WIDTH-1:0] hit_slot;
   logic                  full;

   always_comb begin
      hit_found = 1'b0;
      hit_slot  = '0;
      for (int i = 0; i < MAX_FRAMES; i++) begin
         if (!hit_found && (FILL_WIDTH'(i) < filled_ff) && (frame_page_ff[i] == lookup_page)) begin
            hit_found = 1'b1;
            hit_slot  = SLOT_WIDTH'(i);
         end
      end
   end

   assign full = (filled_ff >= limit);

   always_comb begin
      evicted_page = '0;
      if (hit_found) begin
         kind        = ACC_HIT;
         access_slot = hit_slot;
      end else if (full) begin
         kind         = ACC_EVICT;
         access_slot  = victim_slot;
         evicted_page = frame_page_ff[victim_slot];
      end else begin
         kind        = ACC_FILL;
         access_slot = filled_ff[SLOT_WIDTH-1:0];
      end
   end

   assign filled = filled_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         filled_ff <= '0;
      end else if (upd.en && (upd.kind == ACC_FILL)) begin
         filled_ff <= filled_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (upd.en && (upd.kind != ACC_HIT)) begin
         frame_page_ff[access_slot] <= lookup_page;
      end
   end

endmodule

### sv/lpr_recency.sv
// Recency list: filled slots ordered least recent first, with the
// move-to-most-recent update. Depends on lpr_pkg.
module lpr_recency
   import lpr_pkg::*;
#(
   parameter int MAX_FRAMES = DEF_MAX_FRAMES,
   localparam int SLOT_WIDTH = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1,
   localparam int FILL_WIDTH = $clog2(MAX_FRAMES + 1)
) (
   input  logic                  clock,
   input  lpr_update_type        upd,
   input  logic [SLOT_WIDTH-1:0] access_slot,
   input  logic [FILL_WIDTH-1:0] filled,
   output logic [SLOT_WIDTH-1:0] victim_slot
);

   logic [SLOT_WIDTH-1:0] order_ff [MAX_FRAMES];
   logic [SLOT_WIDTH-1:0] order_in [MAX_FRAMES];
   logic [SLOT_WIDTH-1:0] shifted  [MAX_FRAMES];
   logic [FILL_WIDTH-1:0] pos;
   logic [FILL_WIDTH-1:0] last;
   logic                  pos_found;

   assign victim_slot = order_ff[0];
   assign last        = filled - 1'b1;

   // on eviction the slot is order_ff[0], so the search lands on position zero
   always_comb begin
      pos_found = 1'b0;
      pos       = '0;
      for (int i = 0; i < MAX_FRAMES; i++) begin
         if (!pos_found && (FILL_WIDTH'(i) < filled) && (order_ff[i] == access_slot)) begin
            pos_found = 1'b1;
            pos       = FILL_WIDTH'(i);
         end
      end
   end

   always_comb begin
      for (int i = 0; i < MAX_FRAMES - 1; i++) begin
         shifted[i] = order_ff[i + 1];
      end
      shifted[MAX_FRAMES-1] = order_ff[MAX_FRAMES-1];
   end

   always_comb begin
      for (int i = 0; i < MAX_FRAMES; i++) begin
         order_in[i] = order_ff[i];
         if (upd.kind == ACC_FILL) begin
            if (FILL_WIDTH'(i) == filled) begin
               order_in[i] = access_slot;
            end
         end else if (FILL_WIDTH'(i) == last) begin
            order_in[i] = access_slot;
         end else if ((FILL_WIDTH'(i) >= pos) && (FILL_WIDTH'(i) < last)) begin
            order_in[i] = shifted[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (upd.en) begin
         order_ff <= order_in;
      end
   end

endmodule

### sv/lru_page_replacement_unit.sv
// LRU page replacement unit, top level: request and result registers,
// frame-count register, counters. Depends on lpr_pkg, lpr_frame_table,
// lpr_recency and lru_page_replacement_unit_macros.svh.
//
// Usage:
//   req_valid/req_ready carry one page reference per request (req_page).
//   rsp_valid/rsp_ready carry one result per request: hit, slot, evicted
//   page, and saturating hit and fault counts since reset.
//   csr_valid/csr_ready write the number of managed frames
//   (csr_frames_in_use); csr_ready is always high. Write it while idle.
//   The lookup and the recency update complete between the request and
//   result registers. Throughput: one request per cycle while the
//   receiver takes results.
//   When the receiver stalls, one result waits in the result register and
//   one request in the request register; req_ready then drops.
//   Reset empties all frames, clears both counters and sets the frame
//   count to eight. No clearing pass is needed.
`include "lru_page_replacement_unit_macros.svh"

module lru_page_replacement_unit
   import lpr_pkg::*;
#(
   parameter int MAX_FRAMES  = DEF_MAX_FRAMES,
   parameter int PAGE_WIDTH  = DEF_PAGE_WIDTH,
   parameter int COUNT_WIDTH = DEF_COUNT_WIDTH,
   localparam int SLOT_WIDTH = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1,
   localparam int FILL_WIDTH = $clog2(MAX_FRAMES + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [PAGE_WIDTH-1:0]  req_page,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_hit,
   output logic [SLOT_WIDTH-1:0]  rsp_slot,
   output logic                   rsp_evicted_valid,
   output logic [PAGE_WIDTH-1:0]  rsp_evicted_page,
   output logic [COUNT_WIDTH-1:0] rsp_hit_count,
   output logic [COUNT_WIDTH-1:0] rsp_fault_count,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CFG_WIDTH-1:0]   csr_frames_in_use
);

   logic                   req_vld_ff;
   logic [PAGE_WIDTH-1:0]  page_ff;
   logic [CFG_WIDTH-1:0]   frames_in_use_ff;
   logic [FILL_WIDTH-1:0]  limit;
   logic                   out_free;
   logic                   advance;
   lpr_update_type         upd;
   acc_kind_type           kind;
   logic [SLOT_WIDTH-1:0]  access_slot;
   logic [SLOT_WIDTH-1:0]  victim_slot;
   logic [PAGE_WIDTH-1:0]  evicted_page;
   logic [FILL_WIDTH-1:0]  filled;
   logic [COUNT_WIDTH-1:0] hit_total_ff;
   logic [COUNT_WIDTH-1:0] hit_total_in;
   logic [COUNT_WIDTH-1:0] fault_total_ff;
   logic [COUNT_WIDTH-1:0] fault_total_in;
   logic                   rsp_valid_ff;
   logic                   rsp_hit_ff;
   logic [SLOT_WIDTH-1:0]  rsp_slot_ff;
   logic                   rsp_evicted_valid_ff;
   logic [PAGE_WIDTH-1:0]  rsp_evicted_page_ff;

   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = req_vld_ff && out_free;
   assign req_ready = !req_vld_ff || out_free;

   // zero acts as one frame, anything above the table size as the table size
   always_comb begin
      if (frames_in_use_ff == '0) begin
         limit = FILL_WIDTH'(1);
      end else if (int'(frames_in_use_ff) > MAX_FRAMES) begin
         limit = FILL_WIDTH'(MAX_FRAMES);
      end else begin
         limit = FILL_WIDTH'(frames_in_use_ff);
      end
   end

   assign upd.en   = advance;
   assign upd.kind = kind;

   lpr_frame_table #(
      .MAX_FRAMES (MAX_FRAMES),
      .PAGE_WIDTH (PAGE_WIDTH)
   ) u_frame_table (
      .clock        (clock),
      .reset        (reset),
      .lookup_page  (page_ff),
      .limit        (limit),
      .victim_slot  (victim_slot),
      .upd          (upd),
      .kind         (kind),
      .access_slot  (access_slot),
      .evicted_page (evicted_page),
      .filled       (filled)
   );

   lpr_recency #(
      .MAX_FRAMES (MAX_FRAMES)
   ) u_recency (
      .clock       (clock),
      .upd         (upd),
      .access_slot (access_slot),
      .filled      (filled),
      .victim_slot (victim_slot)
   );

   always_comb begin
      hit_total_in   = hit_total_ff;
      fault_total_in = fault_total_ff;
      if (kind == ACC_HIT) begin
         if (hit_total_ff != '1) begin
            hit_total_in = hit_total_ff + 1'b1;
         end
      end else if (fault_total_ff != '1) begin
         fault_total_in = fault_total_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_vld_ff       <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         frames_in_use_ff <= CFG_FRAMES_RESET;
         hit_total_ff     <= '0;
         fault_total_ff   <= '0;
      end else begin
         if (req_ready) begin
            req_vld_ff <= req_valid;
         end
         if (out_free) begin
            rsp_valid_ff <= req_vld_ff;
         end
         if (csr_valid) begin
            frames_in_use_ff <= csr_frames_in_use;
         end
         if (advance) begin
            hit_total_ff   <= hit_total_in;
            fault_total_ff <= fault_total_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         page_ff <= req_page;
      end
      if (advance) begin
         rsp_hit_ff           <= (kind == ACC_HIT);
         rsp_slot_ff          <= access_slot;
         rsp_evicted_valid_ff <= (kind == ACC_EVICT);
         rsp_evicted_page_ff  <= evicted_page;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hit           = rsp_hit_ff;
   assign rsp_slot          = rsp_slot_ff;
   assign rsp_evicted_valid = rsp_evicted_valid_ff;
   assign rsp_evicted_page  = rsp_evicted_page_ff;
   assign rsp_hit_count     = hit_total_ff;
   assign rsp_fault_count   = fault_total_ff;

   `LPR_ASSERT_NOW(a_evict_page_zero, rsp_valid_ff && !rsp_evicted_valid_ff, rsp_evicted_page_ff == '0, "evicted page nonzero without eviction")
   `LPR_ASSERT_NOW(a_hit_no_evict, rsp_valid_ff && rsp_hit_ff, !rsp_evicted_valid_ff, "hit reported together with eviction")
   `LPR_ASSERT_NOW(a_evict_needs_frames, advance && (kind == ACC_EVICT), filled != '0, "eviction with no filled frame")
   `LPR_ASSERT_NEXT(a_hit_keeps_faults, advance && (kind == ACC_HIT), fault_total_ff == $past(fault_total_ff), "fault count moved on a hit")

endmodule

### tb/lru_page_replacement_unit_tb.sv
// Testbench for lru_page_replacement_unit: random and directed page references
// checked against an LRU frame tracker class. Depends on lpr_pkg and the RTL.
// Covers frame-count changes, shrinking while filled, and long result stalls.
module lru_page_replacement_unit_tb;
   import lpr_pkg::*;

   localparam int NUM_FRAMES  = 8;
   localparam int CYCLE_LIMIT = 1000000;

   typedef struct packed {
      logic        hit;
      logic [2:0]  slot;
      logic        evicted_valid;
      logic [7:0]  evicted_page;
      logic [15:0] hit_count;
      logic [15:0] fault_count;
   } page_outcome_type;

   class lru_tracker;
      logic [7:0]       frame_page [NUM_FRAMES];
      logic [2:0]       recency [NUM_FRAMES];
      int               filled;
      logic [15:0]      hits;
      logic [15:0]      faults;
      logic [3:0]       frames_cfg;
      page_outcome_type pending_outcomes [$];
      int               errors;

      function new();
         for (int i = 0; i < NUM_FRAMES; i++) begin
            frame_page[i] = '0;
            recency[i] = '0;
         end
         filled = 0;
         hits = '0;
         faults = '0;
         frames_cfg = CFG_FRAMES_RESET;
         errors = 0;
      endfunction

      function void set_frames(logic [3:0] v);
         frames_cfg = v;
      endfunction

      function int pending();
         return pending_outcomes.size();
      endfunction

      // move recency entry at pos to the most recent end
      function void promote(int pos);
         logic [2:0] s;
         if (pos >= filled) return;
         s = recency[pos];
         for (int i = pos; i + 1 < filled; i++) recency[i] = recency[i + 1];
         recency[filled - 1] = s;
      endfunction

      function void note_reference(logic [7:0] page);
         int               limit;
         int               slot;
         bit               found;
         page_outcome_type o;
         limit = frames_cfg;
         if (limit < 1) limit = 1;
         if (limit > NUM_FRAMES) limit = NUM_FRAMES;
         found = 0;
         slot = 0;
         o = '0;
         for (int i = 0; i < filled; i++) begin
            if (!found && frame_page[i] == page) begin
               found = 1;
               slot = i;
            end
         end
         if (found) begin
            if (hits != 16'hFFFF) hits++;
            for (int i = 0; i < filled; i++) begin
               if (recency[i] == slot) begin
                  promote(i);
                  break;
               end
            end
         end else begin
            if (faults != 16'hFFFF) faults++;
            if (filled < limit) begin
               slot = filled;
               frame_page[slot] = page;
               recency[filled] = 3'(slot);
               filled++;
            end else begin
               slot = recency[0];
               o.evicted_valid = 1'b1;
               o.evicted_page = frame_page[slot];
               frame_page[slot] = page;
               promote(0);
            end
         end
         o.hit = found;
         o.slot = 3'(slot);
         o.hit_count = hits;
         o.fault_count = faults;
         pending_outcomes.push_back(o);
      endfunction

      function void report(string what, longint want, longint got);
         errors++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      endfunction

      function void check_outcome(page_outcome_type got);
         page_outcome_type want;
         if (pending_outcomes.size() == 0) begin
            errors++;
            $display("%0t: result with no request outstanding", $time);
            return;
         end
         want = pending_outcomes.pop_front();
         if (got.hit !== want.hit) report("hit", want.hit, got.hit);
         if (got.slot !== want.slot) report("slot", want.slot, got.slot);
         if (got.evicted_valid !== want.evicted_valid)
            report("evicted_valid", want.evicted_valid, got.evicted_valid);
         if (got.evicted_page !== want.evicted_page)
            report("evicted_page", want.evicted_page, got.evicted_page);
         if (got.hit_count !== want.hit_count)
            report("hit_count", want.hit_count, got.hit_count);
         if (got.fault_count !== want.fault_count)
            report("fault_count", want.fault_count, got.fault_count);
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [7:0]           req_page = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic                 rsp_hit;
   logic [2:0]           rsp_slot;
   logic                 rsp_evicted_valid;
   logic [7:0]           rsp_evicted_page;
   logic [15:0]          rsp_hit_count;
   logic [15:0]          rsp_fault_count;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CFG_WIDTH-1:0] csr_frames_in_use = '0;

   lru_tracker tracker = new();
   bit         tx_idle = 1'b1;
   bit         rx_idle = 1'b1;
   int         hold_cycles = 0;
   int         cycles = 0;

   always #6 clock = ~clock;

   lru_page_replacement_unit DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_page          (req_page),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_hit           (rsp_hit),
      .rsp_slot          (rsp_slot),
      .rsp_evicted_valid (rsp_evicted_valid),
      .rsp_evicted_page  (rsp_evicted_page),
      .rsp_hit_count     (rsp_hit_count),
      .rsp_fault_count   (rsp_fault_count),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_frames_in_use (csr_frames_in_use)
   );

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // observe every handshake at the edge where it completes
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) tracker.set_frames(csr_frames_in_use);
         if (req_valid && req_ready) tracker.note_reference(req_page);
         if (rsp_valid && rsp_ready)
            tracker.check_outcome({rsp_hit, rsp_slot, rsp_evicted_valid, rsp_evicted_page,
                                   rsp_hit_count, rsp_fault_count});
      end
   end

   // result side: random stalls, plus an optional long hold-off
   initial begin
      int stall;
      while (reset) @(posedge clock);
      forever begin
         if (hold_cycles > 0) begin
            rsp_ready <= 1'b0;
            repeat (hold_cycles) @(posedge clock);
            hold_cycles = 0;
         end
         stall = rx_idle ? $urandom_range(0, 7) : 0;
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   task automatic send_page(input logic [7:0] page);
      int gap;
      gap = tx_idle ? $urandom_range(0, 7) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_page <= page;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // one edge first so the last request is already noted
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tracker.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_frames(input logic [3:0] v);
      drain();
      csr_valid <= 1'b1;
      csr_frames_in_use <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [7:0] pick_page(int base, int span);
      if ($urandom_range(0, 9) < 7) return 8'(base + $urandom_range(0, span));
      return 8'($urandom_range(0, 255));
   endfunction

   initial begin
      logic [3:0] cfg_list [10];
      int base;
      int span;
      cfg_list = '{4'd8, 4'd1, 4'd15, 4'd0, 4'd4,
                   4'd9, 4'd7, 4'd2, 4'd3, 4'd5};
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // zero frames acts as one
      write_frames(4'd0);
      send_page(8'd10);
      send_page(8'd11);
      send_page(8'd11);
      send_page(8'd0);
      // grow to two frames
      write_frames(4'd2);
      send_page(8'd255);
      send_page(8'd0);
      send_page(8'd3);
      // above the maximum acts as eight
      write_frames(4'd15);
      send_page(8'd85);
      send_page(8'd170);
      send_page(8'd1);
      send_page(8'd2);
      send_page(8'd4);
      send_page(8'd5);
      send_page(8'd6);
      send_page(8'd255);
      // shrink below the filled count
      write_frames(4'd3);
      send_page(8'd2);
      send_page(8'd200);
      send_page(8'd201);
      send_page(8'd2);

      for (int ph = 0; ph < 10; ph++) begin
         write_frames(cfg_list[ph]);
         tx_idle = !(ph == 3 || ph == 5 || ph == 8);
         rx_idle = tx_idle;
         if (ph == 5) hold_cycles = 300;
         span = $urandom_range(3, 12);
         base = $urandom_range(0, 255 - span);
         repeat (125) send_page(pick_page(base, span));
      end

      write_frames(4'd8);
      tx_idle = 1'b1;
      rx_idle = 1'b1;
      repeat (40) send_page(pick_page(100, 10));

      drain();
      repeat (10) @(posedge clock);
      if (tracker.errors == 0 && tracker.pending() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

### sim.f
+incdir+sv
sv/lpr_pkg.sv
sv/lpr_frame_table.sv
sv/lpr_recency.sv
sv/lru_page_replacement_unit.sv
tb/lru_page_replacement_unit_tb.sv
